/* sv/mfbrf_pkg.sv */
// mfbrf_pkg: command codes, byte constants and mask helpers for the frame store
// no dependencies
package mfbrf_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_GET   = 2'd2;
    localparam logic [1:0] ACT_FILL  = 2'd3;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] BYTE_BLACK = 8'h00;
    localparam logic [2:0] BIT_FIRST  = 3'd0;
    localparam logic [2:0] BIT_LAST   = 3'd7;

    localparam int Q_DEPTH = 2;

    // pixel i of a byte sits in bit 7-i
    function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[7-i] = (3'(i) >= lo) && (3'(i) <= hi);
        end
        return m;
    endfunction

    function automatic logic [7:0] paint(input logic [7:0] old, input logic [7:0] mask,
                                         input logic white);
        return white ? (old | mask) : (old & ~mask);
    endfunction

endpackage

/* sv/mfbrf_if.sv */
// mfbrf_cmd_if, mfbrf_pix_if: valid/ready channels for commands and pixel reads
// no dependencies
interface mfbrf_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic               colour_white;

    modport source (output valid, action, pos_x, pos_y, rect_width, rect_height,
                    colour_white, input ready);
    modport sink (input valid, action, pos_x, pos_y, rect_width, rect_height,
                  colour_white, output ready);
endinterface

interface mfbrf_pix_if;
    logic valid;
    logic ready;
    logic pixel_white;

    modport source (output valid, pixel_white, input ready);
    modport sink (input valid, pixel_white, output ready);
endinterface

/* sv/mfbrf_ram.sv */
// mfbrf_ram: generic one-write one-read RAM with registered read data
// no dependencies
module mfbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mfbrf_queue.sv */
// mfbrf_queue: short fifo between command front end and store sequencer
// depends on mfbrf_pkg
module mfbrf_queue import mfbrf_pkg::*; #(
    parameter type t_entry = logic
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_entry i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_entry o_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNW = $clog2(Q_DEPTH + 1);

    t_entry          r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CNW-1:0]  r_count;
    logic            push, pop;

    assign o_ready = (r_count != CNW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(Q_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(Q_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* sv/mfbrf_front.sv */
// mfbrf_front: takes commands, clips rectangles, drops no-op commands, queues work
// depends on mfbrf_pkg, mfbrf_if
module mfbrf_front import mfbrf_pkg::*; #(
    parameter int  PANEL_WIDTH  = 128,
    parameter int  PANEL_HEIGHT = 64,
    parameter type t_entry      = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfbrf_cmd_if.sink   i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_entry      o_entry
);

    localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
    localparam int STORE     = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW        = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BCW       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int XW        = $clog2(PANEL_WIDTH + 1);
    localparam int CW        = $clog2(PANEL_WIDTH);
    localparam int YW        = $clog2(PANEL_HEIGHT + 1);
    localparam int ROW_W     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam logic signed [17:0] W_S = 18'(PANEL_WIDTH);
    localparam logic signed [17:0] H_S = 18'(PANEL_HEIGHT);

    logic               r_s1_valid;
    logic [1:0]         r_s1_kind;
    logic               r_s1_white, r_s1_off;
    logic [CW-1:0]      r_s1_left;
    logic [ROW_W-1:0]   r_s1_top;
    logic [XW-1:0]      r_s1_right;
    logic [YW-1:0]      r_s1_bottom;

    logic signed [17:0] x, y, w, h, clip_l, clip_t, clip_r, clip_b;
    logic signed [17:0] left, top, right, bottom;
    logic               on_panel, fill_ok, keep, accept;
    logic [1:0]         kind;
    logic [XW-1:0]      right_m1;

    assign x = {{2{i_cmd.pos_x[15]}}, i_cmd.pos_x};
    assign y = {{2{i_cmd.pos_y[15]}}, i_cmd.pos_y};
    assign w = {{2{i_cmd.rect_width[15]}}, i_cmd.rect_width};
    assign h = {{2{i_cmd.rect_height[15]}}, i_cmd.rect_height};

    always_comb begin
        clip_l   = x[17] ? 18'sd0 : x;
        clip_t   = y[17] ? 18'sd0 : y;
        clip_r   = (x > W_S - w) ? W_S : x + w;
        clip_b   = (y > H_S - h) ? H_S : y + h;
        on_panel = !x[17] && (x < W_S) && !y[17] && (y < H_S);
        fill_ok  = (w > 18'sd0) && (h > 18'sd0) && (clip_r > clip_l) && (clip_b > clip_t);
        kind     = ACT_FILL;
        keep     = 1'b1;
        left     = x;
        top      = y;
        right    = x + 18'sd1;
        bottom   = y + 18'sd1;
        unique case (i_cmd.action)
            ACT_CLEAR: begin
                kind = ACT_CLEAR;
            end
            ACT_SET: begin
                keep = on_panel;
            end
            ACT_GET: begin
                kind = ACT_GET;
            end
            ACT_FILL: begin
                keep   = fill_ok;
                left   = clip_l;
                top    = clip_t;
                right  = clip_r;
                bottom = clip_b;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign i_cmd.ready = !r_s1_valid || i_ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= keep;
        end else if (i_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind   <= kind;
            r_s1_white  <= i_cmd.colour_white;
            r_s1_off    <= !on_panel;
            r_s1_left   <= left[CW-1:0];
            r_s1_top    <= top[ROW_W-1:0];
            r_s1_right  <= right[XW-1:0];
            r_s1_bottom <= bottom[YW-1:0];
        end
    end

    assign right_m1 = r_s1_right - XW'(1);
    assign o_valid  = r_s1_valid;

    always_comb begin
        o_entry.kind  = r_s1_kind;
        o_entry.white = r_s1_white;
        o_entry.off   = r_s1_off;
        o_entry.addr  = AW'(r_s1_top) * AW'(ROW_BYTES) + AW'(r_s1_left >> 3);
        o_entry.first = BCW'(r_s1_left >> 3);
        o_entry.last  = BCW'(right_m1 >> 3);
        o_entry.lo    = r_s1_left[2:0];
        o_entry.hi    = right_m1[2:0];
        o_entry.rows  = r_s1_bottom - YW'(r_s1_top);
    end

endmodule

/* sv/mfbrf_back.sv */
// mfbrf_back: store sequencer, runs clear sweeps, masked byte fills and pixel reads
// depends on mfbrf_pkg, mfbrf_if, mfbrf_ram
module mfbrf_back import mfbrf_pkg::*; #(
    parameter int  PANEL_WIDTH  = 128,
    parameter int  PANEL_HEIGHT = 64,
    parameter type t_entry      = logic
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_entry       i_entry,
    mfbrf_pix_if.source  o_pix
);

    localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
    localparam int STORE     = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW        = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BCW       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int YW        = $clog2(PANEL_HEIGHT + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLEAR    = 3'd1;
    localparam logic [2:0] ST_FILL     = 3'd2;
    localparam logic [2:0] ST_FILL_WR  = 3'd3;
    localparam logic [2:0] ST_GET      = 3'd4;
    localparam logic [2:0] ST_GET_DATA = 3'd5;

    logic [2:0]      r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            r_out_pix, n_out_pix;
    logic [AW-1:0]   r_addr, n_addr, r_row_start, n_row_start;
    logic [BCW-1:0]  r_col, n_col, r_first, r_last;
    logic [2:0]      r_lo, r_hi;
    logic [YW-1:0]   r_rows, n_rows;
    logic            r_white, r_off;

    logic            out_free, load;
    logic [2:0]      lo_eff, hi_eff;
    logic [7:0]      mask;
    logic            ram_we, ram_re;
    logic [7:0]      ram_wdata, ram_rdata;

    mfbrf_ram #(
        .WIDTH (8),
        .DEPTH (STORE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || o_pix.ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign load     = i_valid && o_ready;
    assign lo_eff   = (r_col == r_first) ? r_lo : BIT_FIRST;
    assign hi_eff   = (r_col == r_last) ? r_hi : BIT_LAST;
    assign mask     = span_mask(lo_eff, hi_eff);

    always_comb begin
        n_state     = r_state;
        n_out_valid = (r_out_valid && !o_pix.ready);
        n_out_pix   = r_out_pix;
        n_addr      = r_addr;
        n_row_start = r_row_start;
        n_col       = r_col;
        n_rows      = r_rows;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = r_white ? BYTE_WHITE : BYTE_BLACK;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_addr      = i_entry.addr;
                    n_row_start = i_entry.addr;
                    n_col       = i_entry.first;
                    n_rows      = i_entry.rows;
                    unique case (i_entry.kind)
                        ACT_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        ACT_FILL: n_state = ST_FILL;
                        ACT_GET:  n_state = ST_GET;
                        ACT_SET:  n_state = ST_IDLE;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(STORE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FILL, ST_FILL_WR: begin
                if (r_state == ST_FILL && mask != BYTE_WHITE) begin
                    ram_re  = 1'b1;
                    n_state = ST_FILL_WR;
                end else begin
                    ram_we = 1'b1;
                    if (r_state == ST_FILL_WR) begin
                        ram_wdata = paint(ram_rdata, mask, r_white);
                    end
                    n_state = ST_FILL;
                    if (r_col == r_last) begin
                        if (r_rows == YW'(1)) begin
                            n_state = ST_IDLE;
                        end
                        n_row_start = r_row_start + AW'(ROW_BYTES);
                        n_addr      = r_row_start + AW'(ROW_BYTES);
                        n_col       = r_first;
                        n_rows      = r_rows - YW'(1);
                    end else begin
                        n_addr = r_addr + AW'(1);
                        n_col  = r_col + BCW'(1);
                    end
                end
            end
            ST_GET: begin
                if (r_off) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_pix   = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_GET_DATA;
                end
            end
            ST_GET_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = |(ram_rdata & span_mask(r_lo, r_lo));
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pix   <= n_out_pix;
        r_addr      <= n_addr;
        r_row_start <= n_row_start;
        r_col       <= n_col;
        r_rows      <= n_rows;
        if (load) begin
            r_first <= i_entry.first;
            r_last  <= i_entry.last;
            r_lo    <= i_entry.lo;
            r_hi    <= i_entry.hi;
            r_white <= i_entry.white;
            r_off   <= i_entry.off;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_white = r_out_pix;

endmodule

/* sv/mono_framebuffer_rect_fill.sv */
// mono_framebuffer_rect_fill: one-bit frame store with clipped rectangle fill
// get: front register, queue, byte read, registered pixel; off the panel gives white
// set: sequencer loads the command, then reads and writes back one byte
// clear: one byte per cycle, all ROW_BYTES*PANEL_HEIGHT bytes (1024 by default)
// fill: whole bytes written, partly covered edge bytes read, masked and written back
// reset clears control state and queues; store contents stay undefined until a clear
module mono_framebuffer_rect_fill import mfbrf_pkg::*; #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfbrf_cmd_if.sink   i_cmd,
    mfbrf_pix_if.source o_pix
);

    localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
    localparam int STORE     = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW        = (STORE > 1) ? $clog2(STORE) : 1;
    localparam int BCW       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int YW        = $clog2(PANEL_HEIGHT + 1);

    typedef struct packed {
        logic [1:0]     kind;
        logic           white;
        logic           off;
        logic [AW-1:0]  addr;
        logic [BCW-1:0] first;
        logic [BCW-1:0] last;
        logic [2:0]     lo;
        logic [2:0]     hi;
        logic [YW-1:0]  rows;
    } t_entry;

    logic   f_valid, f_ready, q_valid, q_ready;
    t_entry f_entry, q_entry;

    mfbrf_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .t_entry      (t_entry)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_entry (f_entry)
    );

    mfbrf_queue #(
        .t_entry (t_entry)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_entry),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_entry)
    );

    mfbrf_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .t_entry      (t_entry)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_entry (q_entry),
        .o_pix   (o_pix)
    );

    a_busy_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_ready |=> !q_ready)
        else $error("sequencer took a second item without working the first");

    a_fill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_entry.kind == ACT_FILL |->
            q_entry.rows != '0 && q_entry.first <= q_entry.last)
        else $error("queued fill has an empty span");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("result valid after reset");

endmodule

/* tb/mono_framebuffer_rect_fill_test.sv */
// mono_framebuffer_rect_fill_test: self-checking bench for the one-bit frame store
// drives commands over mfbrf_cmd_if and checks pixel reads from mfbrf_pix_if
// depends on mfbrf_pkg, mfbrf_if.sv and mono_framebuffer_rect_fill
module mono_framebuffer_rect_fill_test;
    import mfbrf_pkg::*;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int TAIL_CYCLES  = 4000;

    typedef struct {
        logic [1:0]         action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic               colour_white;
    } t_fb_cmd;

    typedef struct {
        bit pix;
        int px;
        int py;
    } t_pixel_read;

    logic i_clk;
    logic i_rst_n;

    mfbrf_cmd_if cmd_if();
    mfbrf_pix_if pix_if();

    mono_framebuffer_rect_fill #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    logic [7:0]  frame_bytes [0:STORE_BYTES-1];
    t_pixel_read pending_pixels [$];
    t_pixel_read read_head;
    int          fail_count = 0;
    int          cmd_idle_pct = 0;
    int          pix_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit on_panel(input int x, input int y);
        return x >= 0 && x < PANEL_WIDTH && y >= 0 && y < PANEL_HEIGHT;
    endfunction

    function automatic bit read_pixel(input int x, input int y);
        if (!on_panel(x, y)) begin
            return 1'b1;
        end
        return (frame_bytes[y * ROW_BYTES + x / 8] & (8'h80 >> (x & 7))) != 8'h00;
    endfunction

    task automatic paint_pixel(input int x, input int y, input bit white);
        int idx;
        if (on_panel(x, y)) begin
            idx = y * ROW_BYTES + x / 8;
            if (white) begin
                frame_bytes[idx] = frame_bytes[idx] | (8'h80 >> (x & 7));
            end else begin
                frame_bytes[idx] = frame_bytes[idx] & ~(8'h80 >> (x & 7));
            end
        end
    endtask

    task automatic apply_frame_cmd(input t_fb_cmd c);
        int x, y, w, h;
        int left, top, right, bottom;
        t_pixel_read rd;
        x = c.pos_x;
        y = c.pos_y;
        w = c.rect_width;
        h = c.rect_height;
        case (c.action)
            ACT_CLEAR: begin
                foreach (frame_bytes[i]) begin
                    frame_bytes[i] = c.colour_white ? BYTE_WHITE : BYTE_BLACK;
                end
            end
            ACT_SET: begin
                paint_pixel(x, y, c.colour_white);
            end
            ACT_GET: begin
                rd.pix = read_pixel(x, y);
                rd.px  = x;
                rd.py  = y;
                pending_pixels.push_back(rd);
            end
            default: begin
                if (w > 0 && h > 0) begin
                    left   = (x < 0) ? 0 : x;
                    top    = (y < 0) ? 0 : y;
                    right  = (x > PANEL_WIDTH - w) ? PANEL_WIDTH : x + w;
                    bottom = (y > PANEL_HEIGHT - h) ? PANEL_HEIGHT : y + h;
                    for (int r = top; r < bottom; r++) begin
                        for (int col = left; col < right; col++) begin
                            paint_pixel(col, r, c.colour_white);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic send_cmd(input logic [1:0] action, input int x, input int y,
                            input int w, input int h, input bit white);
        t_fb_cmd c;
        c.action       = action;
        c.pos_x        = 16'(x);
        c.pos_y        = 16'(y);
        c.rect_width   = 16'(w);
        c.rect_height  = 16'(h);
        c.colour_white = white;
        while ($urandom_range(99) < cmd_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.action       <= c.action;
        cmd_if.pos_x        <= c.pos_x;
        cmd_if.pos_y        <= c.pos_y;
        cmd_if.rect_width   <= c.rect_width;
        cmd_if.rect_height  <= c.rect_height;
        cmd_if.colour_white <= c.colour_white;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        apply_frame_cmd(c);
    endtask

    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic int rand_coord(input int span);
        int sel;
        sel = $urandom_range(99);
        if (sel < 80) begin
            return $urandom_range(span - 1);
        end else if (sel < 92) begin
            return int'($urandom_range(span + 16)) - 8;
        end
        return int'($signed(16'($urandom)));
    endfunction

    function automatic int rand_extent(input int short_max);
        int sel;
        sel = $urandom_range(99);
        if (sel < 85) begin
            return $urandom_range(short_max, 1);
        end else if (sel < 92) begin
            return -int'($urandom_range(32768));
        end
        return int'($signed(16'($urandom)));
    endfunction

    // store must be cleared before the first read
    task automatic test_clear();
        send_cmd(ACT_CLEAR, 0, 0, 0, 0, 1'b0);
        send_cmd(ACT_GET, 5, 5, 0, 0, 1'b0);
        send_cmd(ACT_CLEAR, -1, -1, -1, -1, 1'b1);
        send_cmd(ACT_GET, 5, 5, 0, 0, 1'b1);
    endtask

    task automatic test_pixel_edges();
        send_cmd(ACT_SET, 0, 0, 0, 0, 1'b0);
        send_cmd(ACT_SET, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 1'b0);
        send_cmd(ACT_SET, -1, 5, 0, 0, 1'b0);
        send_cmd(ACT_SET, 32767, -32768, 32767, -32768, 1'b0);
        send_cmd(ACT_GET, 0, 0, 0, 0, 1'b0);
        send_cmd(ACT_GET, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 1'b0);
        send_cmd(ACT_GET, -1, 5, 0, 0, 1'b0);
        send_cmd(ACT_GET, PANEL_WIDTH, PANEL_HEIGHT - 1, 0, 0, 1'b0);
        send_cmd(ACT_GET, 0, PANEL_HEIGHT, 0, 0, 1'b0);
        send_cmd(ACT_GET, -32768, 32767, -32768, 32767, 1'b1);
    endtask

    task automatic test_fill_clipping();
        send_cmd(ACT_FILL, 10, 10, 0, 10, 1'b0);
        send_cmd(ACT_FILL, 10, 10, 10, -32768, 1'b0);
        send_cmd(ACT_FILL, -4, -3, 10, 6, 1'b0);
        send_cmd(ACT_GET, 5, 2, 0, 0, 1'b0);
        send_cmd(ACT_GET, 6, 0, 0, 0, 1'b0);
        send_cmd(ACT_FILL, 32767, 0, 32767, 5, 1'b0);
        send_cmd(ACT_FILL, PANEL_WIDTH - 8, PANEL_HEIGHT - 4, 32767, 32767, 1'b0);
        send_cmd(ACT_GET, PANEL_WIDTH - 1, PANEL_HEIGHT - 2, 0, 0, 1'b0);
        send_cmd(ACT_FILL, -32768, -32768, 32767, 32767, 1'b0);
        send_cmd(ACT_FILL, -100, -100, 32767, 32767, 1'b1);
        send_cmd(ACT_GET, PANEL_WIDTH / 2, PANEL_HEIGHT / 2, 0, 0, 1'b0);
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        int sel;
        int x, y, w, h;
        logic [1:0] act;
        cmd_idle_pct  = idle_pct;
        pix_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 2) begin
                act = ACT_CLEAR;
            end else if (sel < 37) begin
                act = ACT_SET;
            end else if (sel < 77) begin
                act = ACT_GET;
            end else begin
                act = ACT_FILL;
            end
            x = rand_coord(PANEL_WIDTH);
            y = rand_coord(PANEL_HEIGHT);
            w = rand_extent(20);
            h = rand_extent(8);
            send_cmd(act, x, y, w, h, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        pix_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pix_if.ready <= ($urandom_range(99) >= pix_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_white: no read pending, actual %0b", pix_if.pixel_white);
                fail_count++;
            end else begin
                read_head = pending_pixels.pop_front();
                if (pix_if.pixel_white !== read_head.pix) begin
                    $error("pixel_white at (%0d,%0d): expected %0b, actual %0b",
                           read_head.px, read_head.py, read_head.pix, pix_if.pixel_white);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.action       <= ACT_CLEAR;
        cmd_if.pos_x        <= '0;
        cmd_if.pos_y        <= '0;
        cmd_if.rect_width   <= '0;
        cmd_if.rect_height  <= '0;
        cmd_if.colour_white <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_clear();
        test_pixel_edges();
        test_fill_clipping();
        hold_until_drained();

        test_random_phase(140, 0, 0);
        hold_until_drained();
        test_random_phase(140, 55, 0);
        hold_until_drained();
        test_random_phase(140, 0, 55);
        hold_until_drained();
        test_random_phase(140, 12, 12);
        hold_until_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* mono_framebuffer_rect_fill.f */
sv/mfbrf_pkg.sv
sv/mfbrf_if.sv
sv/mfbrf_ram.sv
sv/mfbrf_queue.sv
sv/mfbrf_front.sv
sv/mfbrf_back.sv
sv/mono_framebuffer_rect_fill.sv
tb/mono_framebuffer_rect_fill_test.sv
